// File: sv/rtt_pkg.sv
// Package for the repeating timer table: payload structs, operation and
// result codes, and the control struct that steers each cell of the chain.
// No dependencies.
package rtt_pkg;

    // Fixed field widths of the channels
    localparam int OP_BITS   = 2;
    localparam int IN_TIME_W = 32;
    localparam int REP_BITS  = 16;
    localparam int IN_TAG_W  = 16;
    localparam int KIND_BITS = 3;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_UNSCHED  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd3;

    // Result kinds
    localparam logic [KIND_BITS-1:0] K_SCHEDULED = 3'd0;
    localparam logic [KIND_BITS-1:0] K_FULL      = 3'd1;
    localparam logic [KIND_BITS-1:0] K_REMOVED   = 3'd2;
    localparam logic [KIND_BITS-1:0] K_NOT_FOUND = 3'd3;
    localparam logic [KIND_BITS-1:0] K_CLEARED   = 3'd4;
    localparam logic [KIND_BITS-1:0] K_FIRED     = 3'd5;

    typedef struct packed {
        logic [OP_BITS-1:0]   operation;
        logic [IN_TIME_W-1:0] elapsed;
        logic [IN_TIME_W-1:0] period;
        logic [REP_BITS-1:0]  repeat_count;
        logic [IN_TAG_W-1:0]  target_id;
    } t_in_item;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [IN_TAG_W-1:0]  timer_tag;
        logic                 last;
    } t_out_item;

    // Per-cell load selection
    typedef struct packed {
        logic take_next;   // shift from the right-hand neighbour
        logic take_head;   // re-enter the processed head entry at the ring tail
        logic take_new;    // load a freshly scheduled timer
    } t_cell_ctrl;

endpackage

// File: sv/rtt_if.sv
// Valid/ready channel interfaces for the timer table's input and result
// streams. Depends on rtt_pkg for the payload structs.
interface rtt_in_if ();
    import rtt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtt_out_if ();
    import rtt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/repeating_timer_table.sv
// Repeating timer table: up to SLOTS timers held in a chain of cells in
// schedule order. Schedule and clear are taken in idle and give one result.
// Tick and unschedule on a table of live timers pass from the accepting
// state to a pass in which the chain moves one timer per cycle, while no
// firing waits on a full output, through the head unit at cell 0 and back in at
// the ring tail, then to a flush state that delivers the final result. On an
// empty table an unschedule gives its result at once, like schedule, and a tick
// gives none. The result side can stall the pass and the flush. Fired timers are
// reported in table order, the last result of a tick flagged.
module repeating_timer_table #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtt_in_if.sink    i_in,
    rtt_out_if.source o_out
);
    import rtt_pkg::*;

    localparam int EW = TAG_BITS + 2*TIME_BITS + REP_BITS;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]           r_state,    n_state;
    logic [CW-1:0]        r_count,    n_count;
    logic [CW-1:0]        r_left,     n_left;
    logic [TAG_BITS-1:0]  r_next_tag, n_next_tag;
    logic                 r_tick,     n_tick;
    logic [TIME_BITS-1:0] r_elapsed,  n_elapsed;
    logic [TAG_BITS-1:0]  r_target,   n_target;
    logic                 r_found,    n_found;
    logic                 r_pvalid,   n_pvalid;
    logic [TAG_BITS-1:0]  r_ptag,     n_ptag;
    logic                 r_ovalid,   n_ovalid;
    t_out_item            r_out,      n_out;

    logic             out_free;
    logic             in_fire;
    logic             pop;
    logic             sched_write;
    logic             head_fire;
    logic             head_drop;
    logic [EW-1:0]    head_out;
    logic [EW-1:0]    new_entry;
    logic [EW-1:0]    cell_q [SLOTS];
    t_cell_ctrl       cell_ctrl [SLOTS];
    logic [TIME_BITS-1:0] new_period;

    assign out_free   = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign in_fire    = i_in.valid && i_in.ready;

    assign new_period = TIME_BITS'(i_in.data.period);
    assign new_entry  = {r_next_tag, new_period, new_period, i_in.data.repeat_count};

    // Head unit on the entry leaving cell 0
    rtt_head #(
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_head (
        .i_tick    (r_tick),
        .i_elapsed (r_elapsed),
        .i_target  (r_target),
        .i_found   (r_found),
        .i_entry   (cell_q[0]),
        .o_entry   (head_out),
        .o_fire    (head_fire),
        .o_drop    (head_drop)
    );

    // A pop waits only when a firing needs the output and it is still full
    assign pop = (r_state == ST_PASS) &&
                 !(r_tick && head_fire && r_pvalid && !out_free);

    // Cell chain; the ring spans cells below the live count
    for (genvar gi = 0; gi < SLOTS; gi++) begin : g_cell
        logic [EW-1:0] next_q;
        if (gi == SLOTS - 1) begin : g_end
            assign next_q = '0;
        end else begin : g_mid
            assign next_q = cell_q[gi+1];
        end
        assign cell_ctrl[gi].take_next = pop && (CW'(gi + 1) < r_count);
        assign cell_ctrl[gi].take_head = pop && (CW'(gi + 1) == r_count) && !head_drop;
        assign cell_ctrl[gi].take_new  = sched_write && (CW'(gi) == r_count);

        rtt_cell #(
            .W (EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl[gi]),
            .i_next  (next_q),
            .i_head  (head_out),
            .i_new   (new_entry),
            .o_entry (cell_q[gi])
        );
    end

    // Sequencer and result staging
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_next_tag  = r_next_tag;
        n_tick      = r_tick;
        n_elapsed   = r_elapsed;
        n_target    = r_target;
        n_found     = r_found;
        n_pvalid    = r_pvalid;
        n_ptag      = r_ptag;
        n_ovalid    = r_ovalid && !o_out.ready;
        n_out       = r_out;
        sched_write = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.data.operation)
                        OP_SCHEDULE: begin
                            n_ovalid = 1'b1;
                            if (r_count == CW'(SLOTS)) begin
                                n_out = '{kind: K_FULL, timer_tag: '0, last: 1'b1};
                            end else begin
                                sched_write = 1'b1;
                                n_count     = r_count + CW'(1);
                                n_next_tag  = r_next_tag + TAG_BITS'(1);
                                n_out = '{kind: K_SCHEDULED,
                                          timer_tag: IN_TAG_W'(r_next_tag),
                                          last: 1'b1};
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_ovalid = 1'b1;
                            n_out    = '{kind: K_CLEARED, timer_tag: '0, last: 1'b1};
                        end
                        OP_UNSCHED: begin
                            n_tick   = 1'b0;
                            n_target = TAG_BITS'(i_in.data.target_id);
                            n_found  = 1'b0;
                            n_left   = r_count;
                            if (r_count == '0) begin
                                n_ovalid = 1'b1;
                                n_out = '{kind: K_NOT_FOUND,
                                          timer_tag: IN_TAG_W'(TAG_BITS'(i_in.data.target_id)),
                                          last: 1'b1};
                            end else begin
                                n_state = ST_PASS;
                            end
                        end
                        OP_TICK: begin
                            n_tick    = 1'b1;
                            n_elapsed = TIME_BITS'(i_in.data.elapsed);
                            n_pvalid  = 1'b0;
                            n_left    = r_count;
                            if (r_count != '0) begin
                                n_state = ST_PASS;
                            end
                        end
                    endcase
                end
            end
            ST_PASS: begin
                if (pop) begin
                    n_left = r_left - CW'(1);
                    if (head_drop) begin
                        n_count = r_count - CW'(1);
                    end
                    if (!r_tick && head_drop) begin
                        n_found = 1'b1;
                    end
                    // hold the newest firing back until we know if it is the last
                    if (r_tick && head_fire) begin
                        if (r_pvalid) begin
                            n_ovalid = 1'b1;
                            n_out = '{kind: K_FIRED, timer_tag: IN_TAG_W'(r_ptag),
                                      last: 1'b0};
                        end
                        n_pvalid = 1'b1;
                        n_ptag   = cell_q[0][EW-1 -: TAG_BITS];
                    end
                    if (r_left == CW'(1)) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                    if (r_tick) begin
                        if (r_pvalid) begin
                            n_ovalid = 1'b1;
                            n_pvalid = 1'b0;
                            n_out = '{kind: K_FIRED, timer_tag: IN_TAG_W'(r_ptag),
                                      last: 1'b1};
                        end
                    end else begin
                        n_ovalid = 1'b1;
                        n_out = '{kind: r_found ? K_REMOVED : K_NOT_FOUND,
                                  timer_tag: IN_TAG_W'(r_target), last: 1'b1};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_left     <= '0;
            r_next_tag <= '0;
            r_tick     <= 1'b0;
            r_found    <= 1'b0;
            r_pvalid   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_left     <= n_left;
            r_next_tag <= n_next_tag;
            r_tick     <= n_tick;
            r_found    <= n_found;
            r_pvalid   <= n_pvalid;
            r_ovalid   <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
        r_target  <= n_target;
        r_ptag    <= n_ptag;
        r_out     <= n_out;
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // Checks on the sequencer
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("live count above table size");

    a_pass_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> (r_left != '0) && (r_left <= r_count))
        else $error("pass counter out of range");

    a_pending_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvalid |-> (r_state != ST_IDLE) && r_tick)
        else $error("pending firing outside a tick");

    a_sched_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in.data.operation == OP_SCHEDULE) && (r_count != CW'(SLOTS)))
        |=> r_ovalid && (r_out.kind == K_SCHEDULED) && (r_count == $past(r_count) + CW'(1)))
        else $error("schedule transaction without its result");

endmodule

// File: sv/rtt_cell.sv
// One cell of the timer chain: holds a packed timer entry and loads it from
// its neighbour, the processed head entry or a new timer. Uses rtt_pkg.
module rtt_cell #(
    parameter int W = 96
) (
    input  logic                i_clk,
    input  rtt_pkg::t_cell_ctrl i_ctrl,
    input  logic [W-1:0]        i_next,
    input  logic [W-1:0]        i_head,
    input  logic [W-1:0]        i_new,
    output logic [W-1:0]        o_entry
);
    import rtt_pkg::*;

    logic [W-1:0] r_entry;
    logic [W-1:0] n_entry;

    // Load selection; the controls are mutually exclusive
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.take_next) begin
            n_entry = i_next;
        end else if (i_ctrl.take_head) begin
            n_entry = i_head;
        end else if (i_ctrl.take_new) begin
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: sv/rtt_head.sv
// Head processing unit: ages the entry leaving cell 0 during a tick, or
// checks it against the target id during an unschedule. Uses rtt_pkg.
module rtt_head #(
    parameter int TIME_BITS = 32,
    parameter int TAG_BITS  = 16
) (
    input  logic                                             i_tick,
    input  logic [TIME_BITS-1:0]                             i_elapsed,
    input  logic [TAG_BITS-1:0]                              i_target,
    input  logic                                             i_found,
    input  logic [TAG_BITS+2*TIME_BITS+rtt_pkg::REP_BITS-1:0] i_entry,
    output logic [TAG_BITS+2*TIME_BITS+rtt_pkg::REP_BITS-1:0] o_entry,
    output logic                                             o_fire,
    output logic                                             o_drop
);
    import rtt_pkg::*;

    localparam int EW = TAG_BITS + 2*TIME_BITS + REP_BITS;

    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] remaining;
    logic [REP_BITS-1:0]  repeats;
    logic [TIME_BITS-1:0] aged;
    logic [TIME_BITS-1:0] n_remaining;
    logic [REP_BITS-1:0]  n_repeats;

    // Entry layout: {tag, period, remaining, repeats}
    assign tag       = i_entry[EW-1 -: TAG_BITS];
    assign period    = i_entry[2*TIME_BITS+REP_BITS-1 -: TIME_BITS];
    assign remaining = i_entry[TIME_BITS+REP_BITS-1 -: TIME_BITS];
    assign repeats   = i_entry[REP_BITS-1:0];

    // Saturating subtract of the elapsed time
    assign aged = (remaining > i_elapsed) ? (remaining - i_elapsed) : '0;

    always_comb begin
        o_fire      = 1'b0;
        o_drop      = 1'b0;
        n_remaining = remaining;
        n_repeats   = repeats;
        if (i_tick) begin
            n_remaining = aged;
            if (aged == '0) begin
                o_fire = 1'b1;
                if (repeats == REP_BITS'(1)) begin
                    o_drop = 1'b1;
                end else begin
                    // count of zero repeats forever
                    if (repeats != '0) begin
                        n_repeats = repeats - REP_BITS'(1);
                    end
                    n_remaining = period;
                end
            end
        end else begin
            // only the first matching timer goes
            o_drop = !i_found && (tag == i_target);
        end
    end

    assign o_entry = {tag, period, n_remaining, n_repeats};

endmodule
